// ===== hw/rtl/page_signature_compare_core_macros.svh =====
// ----------------------------------------------------------------------------
// page_signature_compare_core_macros.svh
// Assertion macros shared by the page signature compare RTL.
// ----------------------------------------------------------------------------
`ifndef PAGE_SIGNATURE_COMPARE_CORE_MACROS_SVH
`define PAGE_SIGNATURE_COMPARE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define PSC_ASSERT_IMP(label, clk_i, rstn_i, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error("psc assertion failed");

// Next-cycle implication, disabled during reset.
`define PSC_ASSERT_NXT(label, clk_i, rstn_i, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error("psc assertion failed");

`else

`define PSC_ASSERT_IMP(label, clk_i, rstn_i, ante, cons)
`define PSC_ASSERT_NXT(label, clk_i, rstn_i, ante, cons)

`endif

`endif

// ===== hw/rtl/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// Types, constants and helpers of the page signature compare block.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 10;
    localparam int SUM_W    = 22;
    localparam int FAIL_W   = 5;
    localparam int PCT_W    = 7;
    localparam int CIDX_W   = 2;
    localparam int CDATA_W  = 16;

    // Register indexes of the configuration channel
    localparam logic [CIDX_W-1:0] CFG_REL_PCT    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ABS_THR    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_FAIL_LIMIT = 2'd2;

    localparam logic [PCT_W-1:0]   REL_PCT_RESET    = 7'd5;
    localparam logic [COUNT_W-1:0] ABS_THR_RESET    = 16'd6;
    localparam logic [FAIL_W-1:0]  FAIL_LIMIT_RESET = 5'd3;

    localparam logic [FAIL_W-1:0] FAIL_COUNT_MAX = 5'd31;

    // x / 100 for x < 2^29: (x * ceil(2^37 / 100)) >> 37 is exact
    localparam logic [30:0] DIV100_MULT  = 31'd1374389535;
    localparam int          DIV100_SHIFT = 37;

    typedef struct packed {
        logic [PCT_W-1:0]   rel_pct;
        logic [COUNT_W-1:0] abs_thr;
        logic [FAIL_W-1:0]  fail_limit;
    } psc_cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  count_a;
        logic [COUNT_W-1:0]  count_b;
        logic [STATUS_W-1:0] status_a;
        logic [STATUS_W-1:0] status_b;
        logic                text_a;
        logic                text_b;
        logic                last_bucket;
    } psc_item_t;

    // One evaluated bucket pair, ready for accumulation
    typedef struct packed {
        logic signed [COUNT_W:0] diff;
        logic [COUNT_W:0]        scale;
        logic                    fail;
        logic                    meta_diff;
        logic                    last;
    } psc_bucket_t;

    // Totals of one finished comparison
    typedef struct packed {
        logic signed [SUM_W-1:0] diff_sum;
        logic [SUM_W-1:0]        scale_sum;
        logic                    reject;
    } psc_final_t;

    function automatic logic [22:0] div100(input logic [28:0] x);
        logic [59:0] p;
        p = 60'(x) * 60'(DIV100_MULT);
        return p[59:DIV100_SHIFT];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/page_signature_compare_core.sv =====
// ----------------------------------------------------------------------------
// page_signature_compare_core
// Decides whether two response signatures describe the same page.
// ----------------------------------------------------------------------------
// Each transfer on the slave stream carries one pair of bucket counts; tlast
// marks the final pair of a comparison and only then do the status codes and
// text flags in tdata matter. The block takes one transfer every clock cycle
// with no gaps between comparisons of any length, unless a last pair stalls
// behind an untaken verdict. A bucket fails when its absolute difference
// exceeds 1 plus rel_threshold_pct percent of the pair's sum, or exceeds
// abs_threshold. On the last pair one transfer leaves on the master stream
// with bit 0 set when the pages are judged the same: status codes and text
// flags match, no more than bucket_fail_limit buckets failed, and the
// absolute total difference stays within 1 plus the relative share of the
// total sum. The last pair reaches its verdict through the input register,
// two bucket-evaluation stages (multiply by the percent register, then
// divide by 100 through a reciprocal multiply), the accumulator, and two
// verdict stages of the same multiply and divide form. Every stage has its
// own valid bit and holds under backpressure. Write configuration only while
// no comparison is in flight; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module page_signature_compare_core
    import psc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    // Configuration write channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CIDX_W-1:0]  cfg_index,
    input  wire logic [CDATA_W-1:0] cfg_data,

    // Bucket pairs in
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // [15:0] count_a, [31:16] count_b, [41:32] status_a, [51:42] status_b,
    // [52] text_a, [53] text_b, [55:54] zero
    input  wire logic [55:0]        s_tdata,
    input  wire logic               s_tlast,

    // Verdicts out
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [0] same, [7:1] zero
    output logic [7:0]              m_tdata
);

    logic [PCT_W-1:0]   rel_pct_reg, rel_pct_next;
    logic [COUNT_W-1:0] abs_thr_reg, abs_thr_next;
    logic [FAIL_W-1:0]  fail_limit_reg, fail_limit_next;
    psc_cfg_t           cfg;

    psc_item_t   in_item;
    logic        bkt_valid, bkt_ready;
    psc_bucket_t bkt;
    logic        fin_valid, fin_ready;
    psc_final_t  fin;
    logic        same;

    // Configuration registers; writes beyond the register list are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        rel_pct_next    = rel_pct_reg;
        abs_thr_next    = abs_thr_reg;
        fail_limit_next = fail_limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_REL_PCT:    rel_pct_next    = cfg_data[PCT_W-1:0];
                CFG_ABS_THR:    abs_thr_next    = cfg_data[COUNT_W-1:0];
                CFG_FAIL_LIMIT: fail_limit_next = cfg_data[FAIL_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rel_pct_reg    <= REL_PCT_RESET;
            abs_thr_reg    <= ABS_THR_RESET;
            fail_limit_reg <= FAIL_LIMIT_RESET;
        end
        else
        begin
            rel_pct_reg    <= rel_pct_next;
            abs_thr_reg    <= abs_thr_next;
            fail_limit_reg <= fail_limit_next;
        end
    end

    assign cfg.rel_pct    = rel_pct_reg;
    assign cfg.abs_thr    = abs_thr_reg;
    assign cfg.fail_limit = fail_limit_reg;

    // Unpack the slave transfer
    assign in_item.count_a     = s_tdata[15:0];
    assign in_item.count_b     = s_tdata[31:16];
    assign in_item.status_a    = s_tdata[41:32];
    assign in_item.status_b    = s_tdata[51:42];
    assign in_item.text_a      = s_tdata[52];
    assign in_item.text_b      = s_tdata[53];
    assign in_item.last_bucket = s_tlast;

    // Per-bucket evaluation: input register plus two compute stages
    psc_bucket_eval u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .out_valid  (bkt_valid),
        .out_ready  (bkt_ready),
        .out_bucket (bkt)
    );

    // Running sums; only the last pair moves on toward the verdict
    psc_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (bkt_valid),
        .in_ready  (bkt_ready),
        .in_bucket (bkt),
        .out_valid (fin_valid),
        .out_ready (fin_ready),
        .out_final (fin)
    );

    // Total-difference check and result register
    psc_verdict u_verdict (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (fin_valid),
        .in_ready  (fin_ready),
        .in_final  (fin),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .same      (same)
    );

    assign m_tdata = {7'd0, same};

endmodule

`default_nettype wire

// ===== hw/rtl/psc_bucket_eval.sv =====
// ----------------------------------------------------------------------------
// psc_bucket_eval
// Input register and two stages that flag a failed bucket pair.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_signature_compare_core_macros.svh"

module psc_bucket_eval
    import psc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire psc_cfg_t    cfg,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire psc_item_t   in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output psc_bucket_t      out_bucket
);

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s2_ready, s3_ready;

    psc_item_t s1_item_reg;

    logic signed [COUNT_W:0] s2_diff_reg, s2_diff_next;
    logic [COUNT_W-1:0]      s2_adiff_reg, s2_adiff_next;
    logic [COUNT_W:0]        s2_scale_reg, s2_scale_next;
    logic [23:0]             s2_prod_reg, s2_prod_next;
    logic                    s2_abs_fail_reg, s2_abs_fail_next;
    logic                    s2_meta_reg, s2_meta_next;
    logic                    s2_last_reg;

    psc_bucket_t s3_bucket_reg, s3_bucket_next;
    logic [22:0] s3_quot;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign in_ready = !s1_valid_reg || s2_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        s3_valid_next = s3_valid_reg;
        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
        if (s2_ready)
        begin
            s2_valid_next = s1_valid_reg;
        end
        if (s3_ready)
        begin
            s3_valid_next = s2_valid_reg;
        end
    end

    // Stage 2: difference, sum, sum times percent, absolute-threshold and metadata checks
    always_comb
    begin
        s2_diff_next  = $signed({1'b0, s1_item_reg.count_a}) -
                        $signed({1'b0, s1_item_reg.count_b});
        s2_adiff_next = s2_diff_next[COUNT_W] ? COUNT_W'(-s2_diff_next)
                                              : s2_diff_next[COUNT_W-1:0];
        s2_scale_next = {1'b0, s1_item_reg.count_a} + {1'b0, s1_item_reg.count_b};
        s2_prod_next  = 24'(s2_scale_next) * 24'(cfg.rel_pct);
        s2_abs_fail_next = s2_adiff_next > cfg.abs_thr;
        s2_meta_next  = (s1_item_reg.status_a != s1_item_reg.status_b) ||
                        (s1_item_reg.text_a != s1_item_reg.text_b);
    end

    // Stage 3: divide by 100 and compare against the relative bound
    always_comb
    begin
        s3_quot = div100(29'(s2_prod_reg));
        s3_bucket_next.diff      = s2_diff_reg;
        s3_bucket_next.scale     = s2_scale_reg;
        s3_bucket_next.fail      = s2_abs_fail_reg ||
                                   (24'(s2_adiff_reg) > (24'(s3_quot) + 24'd1));
        s3_bucket_next.meta_diff = s2_meta_reg;
        s3_bucket_next.last      = s2_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_diff_reg     <= s2_diff_next;
            s2_adiff_reg    <= s2_adiff_next;
            s2_scale_reg    <= s2_scale_next;
            s2_prod_reg     <= s2_prod_next;
            s2_abs_fail_reg <= s2_abs_fail_next;
            s2_meta_reg     <= s2_meta_next;
            s2_last_reg     <= s1_item_reg.last_bucket;
        end
        if (s2_valid_reg && s3_ready)
        begin
            s3_bucket_reg <= s3_bucket_next;
        end
    end

    assign out_valid  = s3_valid_reg;
    assign out_bucket = s3_bucket_reg;

    `PSC_ASSERT_NXT(a_s3_holds, clk, rst_n, s3_valid_reg && !out_ready, s3_valid_reg)

endmodule

`default_nettype wire

// ===== hw/rtl/psc_accum.sv =====
// ----------------------------------------------------------------------------
// psc_accum
// Running sums and failed-bucket count; hands totals on at the last pair.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_signature_compare_core_macros.svh"

module psc_accum
    import psc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire psc_cfg_t    cfg,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire psc_bucket_t in_bucket,
    output logic             out_valid,
    input  wire logic        out_ready,
    output psc_final_t       out_final
);

    logic [FAIL_W-1:0]       fail_count_reg, fail_count_next;
    logic signed [SUM_W-1:0] diff_sum_reg, diff_sum_next;
    logic [SUM_W-1:0]        scale_sum_reg, scale_sum_next;
    logic                    already_failed_reg, already_failed_next;

    logic                    fin_valid_reg, fin_valid_next;
    psc_final_t              fin_reg;
    logic                    fin_ready;
    logic                    take;

    logic [FAIL_W-1:0]       fc_upd;
    logic                    af_upd;
    logic signed [SUM_W:0]   diff_wide;
    logic signed [SUM_W-1:0] diff_upd;
    logic [SUM_W:0]          scale_wide;
    logic [SUM_W-1:0]        scale_upd;

    assign fin_ready = !fin_valid_reg || out_ready;
    assign in_ready  = !in_bucket.last || fin_ready;
    assign take      = in_valid && in_ready;

    always_comb
    begin
        fc_upd = fail_count_reg;
        af_upd = already_failed_reg;
        if (in_bucket.fail)
        begin
            if (fail_count_reg != FAIL_COUNT_MAX)
            begin
                fc_upd = fail_count_reg + 5'd1;
            end
            af_upd = already_failed_reg || (fc_upd > cfg.fail_limit);
        end

        // Saturate the signed sum on overflow of the top bit
        diff_wide = (SUM_W + 1)'(diff_sum_reg) + (SUM_W + 1)'(in_bucket.diff);
        if (diff_wide[SUM_W] != diff_wide[SUM_W-1])
        begin
            diff_upd = diff_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            diff_upd = diff_wide[SUM_W-1:0];
        end

        scale_wide = {1'b0, scale_sum_reg} + (SUM_W + 1)'(in_bucket.scale);
        scale_upd  = scale_wide[SUM_W] ? {SUM_W{1'b1}} : scale_wide[SUM_W-1:0];
    end

    always_comb
    begin
        fail_count_next     = fail_count_reg;
        diff_sum_next       = diff_sum_reg;
        scale_sum_next      = scale_sum_reg;
        already_failed_next = already_failed_reg;
        fin_valid_next      = fin_valid_reg;
        if (fin_ready)
        begin
            fin_valid_next = take && in_bucket.last;
        end
        if (take)
        begin
            if (in_bucket.last)
            begin
                // Clear the run for the next comparison
                fail_count_next     = '0;
                diff_sum_next       = '0;
                scale_sum_next      = '0;
                already_failed_next = 1'b0;
            end
            else
            begin
                fail_count_next     = fc_upd;
                diff_sum_next       = diff_upd;
                scale_sum_next      = scale_upd;
                already_failed_next = af_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count_reg     <= '0;
            diff_sum_reg       <= '0;
            scale_sum_reg      <= '0;
            already_failed_reg <= 1'b0;
            fin_valid_reg      <= 1'b0;
        end
        else
        begin
            fail_count_reg     <= fail_count_next;
            diff_sum_reg       <= diff_sum_next;
            scale_sum_reg      <= scale_sum_next;
            already_failed_reg <= already_failed_next;
            fin_valid_reg      <= fin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_bucket.last)
        begin
            fin_reg.diff_sum  <= diff_upd;
            fin_reg.scale_sum <= scale_upd;
            fin_reg.reject    <= af_upd || in_bucket.meta_diff;
        end
    end

    assign out_valid = fin_valid_reg;
    assign out_final = fin_reg;

    `PSC_ASSERT_IMP(a_failed_has_count, clk, rst_n, already_failed_reg, fail_count_reg != '0)
    `PSC_ASSERT_NXT(a_clear_after_last, clk, rst_n, take && in_bucket.last, fail_count_reg <= 5'd1)

endmodule

`default_nettype wire

// ===== hw/rtl/psc_verdict.sv =====
// ----------------------------------------------------------------------------
// psc_verdict
// Total-difference check and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_signature_compare_core_macros.svh"

module psc_verdict
    import psc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire psc_cfg_t    cfg,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire psc_final_t  in_final,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             same
);

    logic              v2_valid_reg, v2_valid_next;
    logic              res_valid_reg, res_valid_next;
    logic              res_ready;
    logic [28:0]       v2_prod_reg;
    logic [SUM_W-1:0]  v2_atot_reg, v2_atot_next;
    logic              v2_reject_reg;
    logic [22:0]       quot;
    logic              same_reg, same_next;

    assign res_ready = !res_valid_reg || out_ready;
    assign in_ready  = !v2_valid_reg || res_ready;

    always_comb
    begin
        v2_valid_next  = v2_valid_reg;
        res_valid_next = res_valid_reg;
        if (in_ready)
        begin
            v2_valid_next = in_valid;
        end
        if (res_ready)
        begin
            res_valid_next = v2_valid_reg;
        end

        v2_atot_next = in_final.diff_sum[SUM_W-1] ? SUM_W'(-in_final.diff_sum)
                                                   : in_final.diff_sum;
        quot      = div100(v2_prod_reg);
        same_next = !v2_reject_reg &&
                    !(24'(v2_atot_reg) > (24'(quot) + 24'd1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            v2_valid_reg  <= v2_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            v2_prod_reg   <= 29'(in_final.scale_sum) * 29'(cfg.rel_pct);
            v2_atot_reg   <= v2_atot_next;
            v2_reject_reg <= in_final.reject;
        end
        if (v2_valid_reg && res_ready)
        begin
            same_reg <= same_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign same      = same_reg;

    `PSC_ASSERT_NXT(a_v2_holds, clk, rst_n, v2_valid_reg && !res_ready, v2_valid_reg)

endmodule

`default_nettype wire
